[sv/d3q15ne_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// D3Q15 non-equilibrium part: shared package
// Types, direction codes, rounding constants and the reciprocal helpers that
// the pipeline modules share.
// ----------------------------------------------------------------------------
package d3q15ne_pkg;

	// Lattice direction codes.
	localparam logic [3:0] DIR_REST      = 4'd0;
	localparam logic [3:0] DIR_NEG_X     = 4'd1;
	localparam logic [3:0] DIR_POS_X     = 4'd2;
	localparam logic [3:0] DIR_NEG_Y     = 4'd3;
	localparam logic [3:0] DIR_POS_Y     = 4'd4;
	localparam logic [3:0] DIR_NEG_Z     = 4'd5;
	localparam logic [3:0] DIR_POS_Z     = 4'd6;
	localparam logic [3:0] DIR_DIAG_BASE = 4'd7;
	localparam logic [3:0] DIR_UNUSED    = 4'd15;

	typedef enum logic [1:0] {
		CLS_REST = 2'd0,
		CLS_AXIS = 2'd1,
		CLS_DIAG = 2'd2,
		CLS_NONE = 2'd3
	} cls_t;

	// Half of one Q8.24 unit, for rounding products back to Q8.24.
	localparam logic [63:0] ROUND_HALF = 64'd1 << 23;

	// floor(n / 15) = (n * RECIP15) >> 35 for n < 2^31.
	localparam int          RECIP15_SHIFT = 35;
	localparam logic [31:0] RECIP15 =
		32'(((64'd1 << RECIP15_SHIFT) + 64'd14) / 64'd15);

	// floor(n / 3) = (n * RECIP3) >> 27 for n < 2^26.
	localparam int          RECIP3_SHIFT = 27;
	localparam logic [25:0] RECIP3 =
		26'(((64'd1 << RECIP3_SHIFT) + 64'd2) / 64'd3);

	// Saturation limits of the 32-bit result.
	localparam logic signed [52:0] SAT_MAX = 53'sd2147483647;
	localparam logic signed [52:0] SAT_MIN = -53'sd2147483648;

	// Fields that travel unchanged alongside the arithmetic.
	typedef struct packed {
		logic signed [31:0] f;
		logic signed [31:0] rho;
		logic        [31:0] rmag;
		logic               eos;
	} item_t;

	// Velocity terms and weight, handed from the front end to the divider.
	typedef struct packed {
		item_t              item;
		cls_t               cls;
		logic signed [33:0] ud;
		logic        [41:0] udsq;
		logic        [39:0] usq;
		logic signed [27:0] a;
	} front_t;

	// Rounded bracket and weight, handed from the divider to the back end.
	typedef struct packed {
		item_t              item;
		logic signed [33:0] wa;
		logic               tneg;
		logic        [40:0] tmag;
	} mid_t;

	function automatic logic [31:0] mag32(input logic signed [31:0] x);
		logic [31:0] r;
		r = x[31] ? (~x + 32'd1) : x;
		return r;
	endfunction

	function automatic logic [25:0] div3_26(input logic [25:0] n);
		logic [51:0] p;
		p = 52'(n) * 52'(RECIP3);
		return 26'(p >> RECIP3_SHIFT);
	endfunction

endpackage

[sv/d3q15ne_dist_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// D3Q15 non-equilibrium part: input channel
// One distribution value with its node density, velocity and direction.
// ----------------------------------------------------------------------------
interface d3q15ne_dist_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] dist_value;
	logic        [3:0]  direction;
	logic signed [31:0] node_density;
	logic signed [31:0] velocity_x;
	logic signed [31:0] velocity_y;
	logic signed [31:0] velocity_z;
	logic               end_of_sweep;

	modport source (
		output valid, dist_value, direction, node_density,
		output velocity_x, velocity_y, velocity_z, end_of_sweep,
		input  ready
	);

	modport sink (
		input  valid, dist_value, direction, node_density,
		input  velocity_x, velocity_y, velocity_z, end_of_sweep,
		output ready
	);
endinterface

[sv/d3q15ne_noneq_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// D3Q15 non-equilibrium part: result channel
// Non-equilibrium value with sweep marker and saturation flag.
// ----------------------------------------------------------------------------
interface d3q15ne_noneq_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] noneq_value;
	logic               sweep_done;
	logic               saturated;

	modport source (
		output valid, noneq_value, sweep_done, saturated,
		input  ready
	);

	modport sink (
		input  valid, noneq_value, sweep_done, saturated,
		output ready
	);
endinterface

[sv/d3q15ne_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// D3Q15 non-equilibrium part: front end
// Four stages: direction decode and projection u.e, magnitudes and squares
// of the velocity terms, rounding to Q8.24, and the weight rho/30.
// ----------------------------------------------------------------------------
module d3q15ne_front (
	input  logic                   clk,
	input  logic                   arst_n,
	d3q15ne_dist_if.sink           lattice,
	output d3q15ne_pkg::front_t    out_data,
	output logic                   out_valid,
	input  logic                   out_ready
);
	import d3q15ne_pkg::*;

	logic v_s1, v_s2, v_s3, v_s4;
	logic en_s1, en_s2, en_s3, en_s4;

	assign en_s4 = !v_s4 || out_ready;
	assign en_s3 = !v_s3 || en_s4;
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !v_s1 || en_s2;
	assign lattice.ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= lattice.valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
		end
	end

	// Stage 1: decode and projection.
	cls_t               cls_d;
	logic [2:0]         inc_d;
	logic [2:0]         neg_d;
	logic [3:0]         diag_k;
	logic signed [33:0] vel_w [3];
	logic signed [33:0] term  [3];
	logic signed [33:0] ud_d;

	assign diag_k = lattice.direction - DIR_DIAG_BASE;

	always_comb begin
		cls_d = CLS_NONE;
		inc_d = 3'b000;
		neg_d = 3'b000;
		unique case (lattice.direction)
			DIR_REST:   cls_d = CLS_REST;
			DIR_NEG_X: begin
				cls_d = CLS_AXIS; inc_d = 3'b001; neg_d = 3'b001;
			end
			DIR_POS_X: begin
				cls_d = CLS_AXIS; inc_d = 3'b001;
			end
			DIR_NEG_Y: begin
				cls_d = CLS_AXIS; inc_d = 3'b010; neg_d = 3'b010;
			end
			DIR_POS_Y: begin
				cls_d = CLS_AXIS; inc_d = 3'b010;
			end
			DIR_NEG_Z: begin
				cls_d = CLS_AXIS; inc_d = 3'b100; neg_d = 3'b100;
			end
			DIR_POS_Z: begin
				cls_d = CLS_AXIS; inc_d = 3'b100;
			end
			DIR_UNUSED: cls_d = CLS_NONE;
			default: begin
				cls_d = CLS_DIAG;
				inc_d = 3'b111;
				neg_d = ~diag_k[2:0];
			end
		endcase
	end

	assign vel_w[0] = 34'(lattice.velocity_x);
	assign vel_w[1] = 34'(lattice.velocity_y);
	assign vel_w[2] = 34'(lattice.velocity_z);

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (!inc_d[i]) begin
				term[i] = '0;
			end else if (neg_d[i]) begin
				term[i] = -vel_w[i];
			end else begin
				term[i] = vel_w[i];
			end
		end
		ud_d = term[0] + term[1] + term[2];
	end

	item_t              item_s1;
	cls_t               cls_s1;
	logic signed [33:0] ud_s1;
	logic        [31:0] mx_s1, my_s1, mz_s1;

	always_ff @(posedge clk) begin
		if (en_s1) begin
			item_s1.f    <= lattice.dist_value;
			item_s1.rho  <= lattice.node_density;
			item_s1.rmag <= mag32(lattice.node_density);
			item_s1.eos  <= lattice.end_of_sweep;
			cls_s1       <= cls_d;
			ud_s1        <= ud_d;
			mx_s1        <= mag32(lattice.velocity_x);
			my_s1        <= mag32(lattice.velocity_y);
			mz_s1        <= mag32(lattice.velocity_z);
		end
	end

	// Stage 2: squares of the components, |u.e|, and (|rho| + 15) / 2.
	logic [32:0] udmag_d;
	logic [31:0] rsum_d;

	assign udmag_d = ud_s1[33] ? 33'(-ud_s1) : 33'(ud_s1);
	assign rsum_d  = item_s1.rmag + 32'd15;

	item_t              item_s2;
	cls_t               cls_s2;
	logic signed [33:0] ud_s2;
	logic        [32:0] udmag_s2;
	logic        [63:0] px_s2, py_s2, pz_s2;
	logic        [30:0] a2_s2;

	always_ff @(posedge clk) begin
		if (en_s2) begin
			item_s2  <= item_s1;
			cls_s2   <= cls_s1;
			ud_s2    <= ud_s1;
			udmag_s2 <= udmag_d;
			px_s2    <= 64'(mx_s1) * 64'(mx_s1);
			py_s2    <= 64'(my_s1) * 64'(my_s1);
			pz_s2    <= 64'(mz_s1) * 64'(mz_s1);
			a2_s2    <= rsum_d[31:1];
		end
	end

	// Stage 3: (u.e)^2, rounding of the component squares, rho/30 product.
	logic [63:0] rx_d, ry_d, rz_d;

	assign rx_d = px_s2 + ROUND_HALF;
	assign ry_d = py_s2 + ROUND_HALF;
	assign rz_d = pz_s2 + ROUND_HALF;

	item_t              item_s3;
	cls_t               cls_s3;
	logic signed [33:0] ud_s3;
	logic        [65:0] pud_s3;
	logic        [38:0] sx_s3, sy_s3, sz_s3;
	logic        [62:0] pa_s3;

	always_ff @(posedge clk) begin
		if (en_s3) begin
			item_s3 <= item_s2;
			cls_s3  <= cls_s2;
			ud_s3   <= ud_s2;
			pud_s3  <= 66'(udmag_s2) * 66'(udmag_s2);
			sx_s3   <= rx_d[62:24];
			sy_s3   <= ry_d[62:24];
			sz_s3   <= rz_d[62:24];
			pa_s3   <= 63'(a2_s2) * 63'(RECIP15);
		end
	end

	// Stage 4: |u|^2, rounded (u.e)^2 and the signed weight A.
	logic        [65:0] rud_d;
	logic        [26:0] aq_d;
	logic signed [27:0] a_d;

	assign rud_d = pud_s3 + 66'(ROUND_HALF);
	assign aq_d  = pa_s3[61:35];
	assign a_d   = item_s3.rho[31] ? -$signed({1'b0, aq_d}) : $signed({1'b0, aq_d});

	front_t data_s4;

	always_ff @(posedge clk) begin
		if (en_s4) begin
			data_s4.item <= item_s3;
			data_s4.cls  <= cls_s3;
			data_s4.ud   <= ud_s3;
			data_s4.udsq <= rud_d[65:24];
			data_s4.usq  <= 40'(sx_s3) + 40'(sy_s3) + 40'(sz_s3);
			data_s4.a    <= a_d;
		end
	end

	assign out_data  = data_s4;
	assign out_valid = v_s4;

endmodule

[sv/d3q15ne_div48.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// D3Q15 non-equilibrium part: bracket and divide by 48
// Five stages: class-dependent bracket over 48 and weight, magnitude with
// rounding offset, then a two-step division by 48 using reciprocals of 3.
// ----------------------------------------------------------------------------
module d3q15ne_div48 (
	input  logic                   clk,
	input  logic                   arst_n,
	input  d3q15ne_pkg::front_t    in_data,
	input  logic                   in_valid,
	output logic                   in_ready,
	output d3q15ne_pkg::mid_t      out_data,
	output logic                   out_valid,
	input  logic                   out_ready
);
	import d3q15ne_pkg::*;

	logic v_s5, v_s6, v_s7, v_s8, v_s9;
	logic en_s5, en_s6, en_s7, en_s8, en_s9;

	assign en_s9 = !v_s9 || out_ready;
	assign en_s8 = !v_s8 || en_s9;
	assign en_s7 = !v_s7 || en_s8;
	assign en_s6 = !v_s6 || en_s7;
	assign en_s5 = !v_s5 || en_s6;
	assign in_ready = en_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
		end else begin
			if (en_s5) v_s5 <= in_valid;
			if (en_s6) v_s6 <= v_s5;
			if (en_s7) v_s7 <= v_s6;
			if (en_s8) v_s8 <= v_s7;
			if (en_s9) v_s9 <= v_s8;
		end
	end

	// Stage 5: bracket numerator over 48 and weight for the direction class.
	logic signed [46:0] ud_w, usq_w, udsq_w, n48_d;
	logic signed [33:0] a_w, rho_w, wa_d;

	assign ud_w   = 47'(in_data.ud);
	assign usq_w  = $signed(47'(in_data.usq));
	assign udsq_w = $signed(47'(in_data.udsq));
	assign a_w    = 34'(in_data.a);
	assign rho_w  = 34'(in_data.item.rho);

	always_comb begin
		unique case (in_data.cls)
			CLS_REST: begin
				n48_d = -(usq_w <<< 5);
				wa_d  = rho_w - (a_w <<< 4) + (a_w <<< 1);
			end
			CLS_AXIS: begin
				n48_d = (ud_w <<< 4) - (usq_w <<< 2) + (udsq_w <<< 4) + (udsq_w <<< 3);
				wa_d  = a_w;
			end
			CLS_DIAG: begin
				n48_d = (ud_w <<< 1) - (usq_w <<< 1) + (udsq_w <<< 1) + udsq_w;
				wa_d  = a_w;
			end
			CLS_NONE: begin
				n48_d = '0;
				wa_d  = '0;
			end
		endcase
	end

	item_t              item_s5;
	logic signed [46:0] n48_s5;
	logic signed [33:0] wa_s5;

	always_ff @(posedge clk) begin
		if (en_s5) begin
			item_s5 <= in_data.item;
			n48_s5  <= n48_d;
			wa_s5   <= wa_d;
		end
	end

	// Stage 6: magnitude plus half the divisor.
	logic [46:0] nu_d, m_d;

	assign nu_d = n48_s5;
	assign m_d  = n48_s5[46] ? (~nu_d + 47'd25) : (nu_d + 47'd24);

	item_t              item_s6;
	logic signed [33:0] wa_s6;
	logic               tneg_s6;
	logic        [45:0] m_s6;

	always_ff @(posedge clk) begin
		if (en_s6) begin
			item_s6 <= item_s5;
			wa_s6   <= wa_s5;
			tneg_s6 <= n48_s5[46];
			m_s6    <= m_d[45:0];
		end
	end

	// Stage 7: quotient of the upper part, floor(m[45:24] / 48).
	logic [25:0] qh_d;

	assign qh_d = div3_26(26'(m_s6[45:28]));

	item_t              item_s7;
	logic signed [33:0] wa_s7;
	logic               tneg_s7;
	logic        [45:0] m_s7;
	logic        [16:0] qh_s7;

	always_ff @(posedge clk) begin
		if (en_s7) begin
			item_s7 <= item_s6;
			wa_s7   <= wa_s6;
			tneg_s7 <= tneg_s6;
			m_s7    <= m_s6;
			qh_s7   <= qh_d[16:0];
		end
	end

	// Stage 8: remainder of the upper part joined with the lower bits.
	logic [21:0] rh_d;

	assign rh_d = m_s7[45:24] - {qh_s7, 5'b00000} - 22'({qh_s7, 4'b0000});

	item_t              item_s8;
	logic signed [33:0] wa_s8;
	logic               tneg_s8;
	logic        [16:0] qh_s8;
	logic        [25:0] x_s8;

	always_ff @(posedge clk) begin
		if (en_s8) begin
			item_s8 <= item_s7;
			wa_s8   <= wa_s7;
			tneg_s8 <= tneg_s7;
			qh_s8   <= qh_s7;
			x_s8    <= {rh_d[5:0], m_s7[23:4]};
		end
	end

	// Stage 9: lower quotient digits.
	logic [25:0] ql_d;

	assign ql_d = div3_26(x_s8);

	mid_t data_s9;

	always_ff @(posedge clk) begin
		if (en_s9) begin
			data_s9.item <= item_s8;
			data_s9.wa   <= wa_s8;
			data_s9.tneg <= tneg_s8;
			data_s9.tmag <= {qh_s8, ql_d[23:0]};
		end
	end

	assign out_data  = data_s9;
	assign out_valid = v_s9;

endmodule

[sv/d3q15ne_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// D3Q15 non-equilibrium part: back end
// Four stages: rho times bracket in two partial products, rounding, the
// final difference, and saturation into the output register.
// ----------------------------------------------------------------------------
module d3q15ne_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  d3q15ne_pkg::mid_t      in_data,
	input  logic                   in_valid,
	output logic                   in_ready,
	d3q15ne_noneq_if.source        noneq
);
	import d3q15ne_pkg::*;

	logic v_s10, v_s11, v_s12, v_s13;
	logic en_s10, en_s11, en_s12, en_s13;

	assign en_s13 = !v_s13 || noneq.ready;
	assign en_s12 = !v_s12 || en_s13;
	assign en_s11 = !v_s11 || en_s12;
	assign en_s10 = !v_s10 || en_s11;
	assign in_ready = en_s10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
			v_s12 <= 1'b0;
			v_s13 <= 1'b0;
		end else begin
			if (en_s10) v_s10 <= in_valid;
			if (en_s11) v_s11 <= v_s10;
			if (en_s12) v_s12 <= v_s11;
			if (en_s13) v_s13 <= v_s12;
		end
	end

	// Stage 10: partial products of |rho| and |T|.
	logic signed [31:0] f_s10;
	logic signed [33:0] wa_s10;
	logic               eos_s10, pneg_s10;
	logic        [55:0] pl_s10;
	logic        [48:0] ph_s10;

	always_ff @(posedge clk) begin
		if (en_s10) begin
			f_s10    <= in_data.item.f;
			wa_s10   <= in_data.wa;
			eos_s10  <= in_data.item.eos;
			pneg_s10 <= in_data.item.rho[31] ^ in_data.tneg;
			pl_s10   <= 56'(in_data.item.rmag) * 56'(in_data.tmag[23:0]);
			ph_s10   <= 49'(in_data.item.rmag) * 49'(in_data.tmag[40:24]);
		end
	end

	// Stage 11: recombine and round the product to Q8.24.
	logic [56:0] plr_d;

	assign plr_d = 57'(pl_s10) + 57'(ROUND_HALF);

	logic signed [31:0] f_s11;
	logic signed [33:0] wa_s11;
	logic               eos_s11, pneg_s11;
	logic        [49:0] pm_s11;

	always_ff @(posedge clk) begin
		if (en_s11) begin
			f_s11    <= f_s10;
			wa_s11   <= wa_s10;
			eos_s11  <= eos_s10;
			pneg_s11 <= pneg_s10;
			pm_s11   <= 50'(ph_s10) + 50'(plr_d[56:24]);
		end
	end

	// Stage 12: f - A - P, exact.
	logic signed [52:0] pm_w, pterm_d, diff_d;

	assign pm_w    = $signed({3'b000, pm_s11});
	assign pterm_d = pneg_s11 ? pm_w : -pm_w;
	assign diff_d  = 53'(f_s11) - 53'(wa_s11) + pterm_d;

	logic signed [52:0] diff_s12;
	logic               eos_s12;

	always_ff @(posedge clk) begin
		if (en_s12) begin
			diff_s12 <= diff_d;
			eos_s12  <= eos_s11;
		end
	end

	// Stage 13: saturation into the output register.
	logic signed [31:0] res_d;
	logic               sat_d;

	always_comb begin
		priority if (diff_s12 > SAT_MAX) begin
			res_d = SAT_MAX[31:0];
			sat_d = 1'b1;
		end else if (diff_s12 < SAT_MIN) begin
			res_d = SAT_MIN[31:0];
			sat_d = 1'b1;
		end else begin
			res_d = diff_s12[31:0];
			sat_d = 1'b0;
		end
	end

	logic signed [31:0] res_s13;
	logic               eos_s13, sat_s13;

	always_ff @(posedge clk) begin
		if (en_s13) begin
			res_s13 <= res_d;
			sat_s13 <= sat_d;
			eos_s13 <= eos_s12;
		end
	end

	assign noneq.valid       = v_s13;
	assign noneq.noneq_value = res_s13;
	assign noneq.sweep_done  = eos_s13;
	assign noneq.saturated   = sat_s13;

endmodule

[sv/d3q15_nonequilibrium_part.sv]
`timescale 1ns / 1ps
// Throughput: one request per cycle while the output is ready, set by a
// 13-stage pipeline in which every stage takes a new item each cycle unless
// held; a stalled output holds its stage and bubbles ahead of it still fill.
// Reset clears only the stage valid bits.
// ----------------------------------------------------------------------------
// D3Q15 non-equilibrium part
// Returns one lattice distribution value minus its compressible equilibrium,
// in signed Q8.24 with saturation, one result per request.
// ----------------------------------------------------------------------------
module d3q15_nonequilibrium_part (
	input  logic             clk,
	input  logic             arst_n,
	d3q15ne_dist_if.sink     lattice,
	d3q15ne_noneq_if.source  noneq
);
	import d3q15ne_pkg::*;

	front_t front_data;
	logic   front_valid, front_ready;
	mid_t   mid_data;
	logic   mid_valid, mid_ready;

	d3q15ne_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.lattice   (lattice),
		.out_data  (front_data),
		.out_valid (front_valid),
		.out_ready (front_ready)
	);

	d3q15ne_div48 u_div48 (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (front_data),
		.in_valid  (front_valid),
		.in_ready  (front_ready),
		.out_data  (mid_data),
		.out_valid (mid_valid),
		.out_ready (mid_ready)
	);

	d3q15ne_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (mid_data),
		.in_valid (mid_valid),
		.in_ready (mid_ready),
		.noneq    (noneq)
	);

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// D3Q15 non-equilibrium part: testbench
// Streams distribution requests into the block and checks every result
// against a fixed-point predictor of f minus the compressible equilibrium.
// A directed set covers every direction, the field extremes, the upper
// saturation limit and the unused direction. Random requests follow, half
// physical values and half full-range or corner values. Both handshake sides
// idle at random, and the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb;
	import d3q15ne_pkg::*;

	typedef struct packed {
		logic signed [31:0] f;
		logic        [3:0]  dir;
		logic signed [31:0] rho;
		logic signed [31:0] ux;
		logic signed [31:0] uy;
		logic signed [31:0] uz;
		logic               eos;
	} dist_req_t;

	typedef struct packed {
		logic signed [31:0] value;
		logic               done;
		logic               sat;
	} noneq_t;

	localparam logic signed [31:0] Q_ONE = 32'sd16777216;
	localparam logic signed [31:0] Q_MAX = 32'sh7FFFFFFF;
	localparam logic signed [31:0] Q_MIN = 32'sh80000000;
	localparam longint SAT_HI = 64'sd2147483647;
	localparam longint SAT_LO = -64'sd2147483648;
	localparam int LIMIT = 400000;
	localparam int LONG_STALL_AT = 300;
	localparam int LONG_STALL = 300;
	localparam int RANDOM_BATCH = 700;

	logic clk = 1'b0;
	logic arst_n;

	d3q15ne_dist_if  dist_ch ();
	d3q15ne_noneq_if noneq_ch ();

	d3q15_nonequilibrium_part u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.lattice (dist_ch),
		.noneq   (noneq_ch)
	);

	dist_req_t req_queue[$];
	noneq_t    noneq_expected[$];
	dist_req_t offered;
	int        failures = 0;
	int        results_seen = 0;
	int        cycles = 0;
	int        tx_wait, tx_run, rx_wait, rx_run, hold_left;

	always #4 clk = ~clk;

	function automatic int draw_wait(inout int run_left);
		if (run_left > 0) begin
			run_left--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0) begin
			run_left = $urandom_range(20, 60);
			return 0;
		end
		return $urandom_range(0, 13);
	endfunction

	function automatic longint round_div(longint n, longint d);
		longint q;
		q = ((n < 0 ? -n : n) + d / 2) / d;
		return n < 0 ? -q : q;
	endfunction

	function automatic longint square_q(longint x);
		logic [127:0] m;
		m = x < 0 ? -x : x;
		m = (m * m + ROUND_HALF) >> 24;
		return longint'(m[63:0]);
	endfunction

	function automatic longint scale_q(longint r, longint t);
		logic [127:0] mr, mt, p;
		mr = r < 0 ? -r : r;
		mt = t < 0 ? -t : t;
		p = (mr * mt + ROUND_HALF) >> 24;
		return ((r < 0) != (t < 0)) ? -longint'(p[63:0]) : longint'(p[63:0]);
	endfunction

	function automatic noneq_t noneq_of(dist_req_t it);
		noneq_t     r;
		cls_t       cls;
		logic [3:0] k;
		longint     f, rho, ux, uy, uz, ex, ey, ez, s;
		longint     a, usq, ud, udsq, n48, wa, res;
		f = $signed(it.f);
		rho = $signed(it.rho);
		ux = $signed(it.ux);
		uy = $signed(it.uy);
		uz = $signed(it.uz);
		ex = 0;
		ey = 0;
		ez = 0;
		r.done = it.eos;
		r.sat = 1'b0;
		if (it.dir == DIR_UNUSED) begin
			res = f;
		end else begin
			if (it.dir == DIR_REST) begin
				cls = CLS_REST;
			end else if (it.dir < DIR_DIAG_BASE) begin
				cls = CLS_AXIS;
				s = it.dir[0] ? -1 : 1;
				if (it.dir <= DIR_POS_X) ex = s;
				else if (it.dir <= DIR_POS_Y) ey = s;
				else ez = s;
			end else begin
				cls = CLS_DIAG;
				k = it.dir - DIR_DIAG_BASE;
				ex = k[0] ? 1 : -1;
				ey = k[1] ? 1 : -1;
				ez = k[2] ? 1 : -1;
			end
			a = round_div(rho, 30);
			usq = square_q(ux) + square_q(uy) + square_q(uz);
			ud = ex * ux + ey * uy + ez * uz;
			udsq = square_q(ud);
			case (cls)
				CLS_REST: begin
					n48 = -32 * usq;
					wa = rho - 14 * a;
				end
				CLS_AXIS: begin
					n48 = 16 * ud - 4 * usq + 24 * udsq;
					wa = a;
				end
				default: begin
					n48 = 2 * ud - 2 * usq + 3 * udsq;
					wa = a;
				end
			endcase
			res = f - wa - scale_q(rho, round_div(n48, 48));
		end
		if (res > SAT_HI) begin
			res = SAT_HI;
			r.sat = 1'b1;
		end else if (res < SAT_LO) begin
			res = SAT_LO;
			r.sat = 1'b1;
		end
		r.value = res[31:0];
		return r;
	endfunction

	function automatic dist_req_t request(logic signed [31:0] f, logic [3:0] dir,
			logic signed [31:0] rho, logic signed [31:0] ux, logic signed [31:0] uy,
			logic signed [31:0] uz, logic eos);
		dist_req_t it;
		it.f = f;
		it.dir = dir;
		it.rho = rho;
		it.ux = ux;
		it.uy = uy;
		it.uz = uz;
		it.eos = eos;
		return it;
	endfunction

	function automatic logic signed [31:0] corner_value();
		case ($urandom_range(0, 7))
			0: return Q_MAX;
			1: return Q_MIN;
			2: return 32'sd0;
			3: return -32'sd1;
			4: return 32'sd1;
			5: return Q_ONE;
			6: return -Q_ONE;
			default: return $urandom;
		endcase
	endfunction

	task automatic wait_drained();
		while (req_queue.size() != 0 || dist_ch.valid || noneq_expected.size() != 0)
			@(negedge clk);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dist_ch.valid <= 1'b0;
			dist_ch.dist_value <= '0;
			dist_ch.direction <= DIR_REST;
			dist_ch.node_density <= '0;
			dist_ch.velocity_x <= '0;
			dist_ch.velocity_y <= '0;
			dist_ch.velocity_z <= '0;
			dist_ch.end_of_sweep <= 1'b0;
			tx_wait = 0;
			tx_run = 0;
		end else begin
			if (dist_ch.valid && dist_ch.ready)
				noneq_expected.push_back(noneq_of(offered));
			if (!dist_ch.valid || dist_ch.ready) begin
				if (tx_wait > 0) begin
					tx_wait--;
					dist_ch.valid <= 1'b0;
				end else if (req_queue.size() > 0) begin
					offered = req_queue.pop_front();
					dist_ch.dist_value <= offered.f;
					dist_ch.direction <= offered.dir;
					dist_ch.node_density <= offered.rho;
					dist_ch.velocity_x <= offered.ux;
					dist_ch.velocity_y <= offered.uy;
					dist_ch.velocity_z <= offered.uz;
					dist_ch.end_of_sweep <= offered.eos;
					dist_ch.valid <= 1'b1;
					tx_wait = draw_wait(tx_run);
				end else begin
					dist_ch.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		noneq_t want;
		if (!arst_n) begin
			noneq_ch.ready <= 1'b0;
			rx_wait = 0;
			rx_run = 0;
			hold_left = 0;
		end else begin
			if (noneq_ch.valid && noneq_ch.ready) begin
				results_seen++;
				if (noneq_expected.size() == 0) begin
					$error("unexpected result: noneq_value %0d", noneq_ch.noneq_value);
					failures++;
				end else begin
					want = noneq_expected.pop_front();
					if (noneq_ch.noneq_value !== want.value) begin
						$error("noneq_value: expected %0d, actual %0d",
							want.value, noneq_ch.noneq_value);
						failures++;
					end
					if (noneq_ch.sweep_done !== want.done) begin
						$error("sweep_done: expected %0b, actual %0b",
							want.done, noneq_ch.sweep_done);
						failures++;
					end
					if (noneq_ch.saturated !== want.sat) begin
						$error("saturated: expected %0b, actual %0b",
							want.sat, noneq_ch.saturated);
						failures++;
					end
				end
				if (results_seen == LONG_STALL_AT) hold_left = LONG_STALL;
				else rx_wait = draw_wait(rx_run);
			end
			if (hold_left > 0) begin
				hold_left--;
				noneq_ch.ready <= 1'b0;
			end else if (rx_wait > 0) begin
				rx_wait--;
				noneq_ch.ready <= 1'b0;
			end else begin
				noneq_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == LIMIT) begin
			$display("d3q15_nonequilibrium_part verification failed");
			$finish;
		end
	end

	initial begin
		dist_req_t it;
		arst_n = 1'b1;
		#2;
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		for (int d = 0; d < 16; d++)
			req_queue.push_back(request(32'sh00400000 + d, 4'(d), Q_ONE + 32'sd3000 * d,
				32'sd1677722, -32'sd838861, 32'sd1174405, d[0]));
		req_queue.push_back(request(Q_MAX, DIR_REST, Q_MAX, Q_MAX, Q_MAX, Q_MAX, 1'b1));
		req_queue.push_back(request(Q_MIN, DIR_DIAG_BASE, Q_MIN, Q_MIN, Q_MIN, Q_MIN, 1'b0));
		req_queue.push_back(request(32'sd0, DIR_DIAG_BASE + 4'd7, Q_MIN, Q_MAX, Q_MAX, Q_MAX,
			1'b1));
		req_queue.push_back(request(Q_MAX, DIR_POS_X, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 1'b0));
		req_queue.push_back(request(Q_MIN, DIR_NEG_Y, Q_ONE, Q_MAX, 32'sd0, 32'sd0, 1'b0));
		req_queue.push_back(request(Q_MAX, DIR_NEG_Z, -Q_ONE, 32'sd0, 32'sd0, 32'sd0, 1'b1));
		req_queue.push_back(request(Q_MIN, DIR_UNUSED, Q_MAX, Q_MAX, Q_MIN, Q_MAX, 1'b1));
		req_queue.push_back(request(32'sd0, DIR_REST, Q_MAX, 32'sd0, 32'sd0, 32'sd0, 1'b0));
		wait_drained();

		for (int b = 0; b < 2; b++) begin
			for (int i = 0; i < RANDOM_BATCH; i++) begin
				case ($urandom_range(0, 3))
					0, 1: begin
						it.rho = Q_ONE + int'($urandom_range(0, 1 << 23)) - (1 << 22);
						it.ux = int'($urandom_range(0, 1 << 23)) - (1 << 22);
						it.uy = int'($urandom_range(0, 1 << 23)) - (1 << 22);
						it.uz = int'($urandom_range(0, 1 << 23)) - (1 << 22);
						it.f = int'($urandom_range(0, 1 << 23)) - (1 << 21);
						it.dir = ($urandom_range(0, 31) == 0) ? DIR_UNUSED :
							4'($urandom_range(0, 14));
					end
					2: begin
						it.f = $urandom;
						it.rho = $urandom;
						it.ux = $urandom;
						it.uy = $urandom;
						it.uz = $urandom;
						it.dir = 4'($urandom_range(0, 15));
					end
					default: begin
						it.f = corner_value();
						it.rho = corner_value();
						it.ux = corner_value();
						it.uy = corner_value();
						it.uz = corner_value();
						it.dir = 4'($urandom_range(0, 15));
					end
				endcase
				it.eos = 1'($urandom_range(0, 1));
				req_queue.push_back(it);
			end
			wait_drained();
		end

		repeat (40) @(posedge clk);
		if (failures == 0)
			$display("d3q15_nonequilibrium_part verification clean");
		else
			$display("d3q15_nonequilibrium_part verification failed");
		$finish;
	end
endmodule
